// ===== rtl/core/cht_pkg.sv =====
`timescale 1ns / 1ps

package cht_pkg;

   localparam int BUCKETS_DEF = 10;
   localparam int DEPTH_DEF   = 8;

   localparam int OP_W  = 2;
   localparam int KEY_W = 63;
   localparam int STS_W = 2;

   // bucket index: key is reduced one 8-bit chunk per cycle, MSB first
   localparam int CHUNK_W   = 8;
   localparam int MOD_STEPS = 8;
   localparam int MODCNT_W  = 3;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

   localparam logic [STS_W-1:0] STS_OK     = 2'd0;
   localparam logic [STS_W-1:0] STS_FULL   = 2'd1;
   localparam logic [STS_W-1:0] STS_ABSENT = 2'd2;

   typedef enum logic [3:0] {
      CS_IDLE,
      CS_MOD,
      CS_FILL,
      CS_SCAN_RD,
      CS_SCAN_CMP,
      CS_DECIDE,
      CS_INSERT,
      CS_SHIFT_RD,
      CS_SHIFT_WR,
      CS_DEL_FILL,
      CS_DONE
   } ctl_state_type;

   typedef struct packed {
      logic load;
      logic mod_step;
      logic fill_rd;
      logic scan_rd;
      logic scan_cmp;
      logic shift_rd;
      logic shift_wr;
      logic ins_wr;
      logic del_fill;
      logic rsp_load;
   } cht_cmd_type;

   typedef struct packed {
      logic mod_last;
      logic is_nop;
      logic is_insert;
      logic is_delete;
      logic scan_end;
      logic match;
      logic hit;
      logic full;
      logic shift_end;
      logic rsp_free;
   } cht_sts_type;

endpackage

// ===== rtl/core/cht_if.sv =====
`timescale 1ns / 1ps

interface cht_req_if import cht_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [OP_W-1:0]  opcode;
   logic [KEY_W-1:0] key;

   modport source (output valid, output opcode, output key, input ready);
   modport sink   (input valid, input opcode, input key, output ready);
endinterface

interface cht_rsp_if import cht_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             found;
   logic [STS_W-1:0] status;

   modport source (output valid, output found, output status, input ready);
   modport sink   (input valid, input found, input status, output ready);
endinterface

// ===== rtl/core/cht_ctrl.sv =====
`timescale 1ns / 1ps

module cht_ctrl import cht_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  cht_sts_type sts,
   output cht_cmd_type cmd
);

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         CS_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = CS_MOD;
            end
         end
         CS_MOD: begin
            cmd.mod_step = 1'b1;
            if (sts.mod_last) begin
               state_in = sts.is_nop ? CS_DONE : CS_FILL;
            end
         end
         CS_FILL: begin
            cmd.fill_rd = 1'b1;
            state_in    = CS_SCAN_RD;
         end
         CS_SCAN_RD: begin
            if (sts.scan_end) begin
               state_in = CS_DECIDE;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in    = CS_SCAN_CMP;
            end
         end
         CS_SCAN_CMP: begin
            cmd.scan_cmp = 1'b1;
            state_in     = sts.match ? CS_DECIDE : CS_SCAN_RD;
         end
         CS_DECIDE: begin
            priority if (sts.is_insert) begin
               state_in = sts.full ? CS_DONE : CS_INSERT;
            end else if (sts.is_delete) begin
               state_in = sts.hit ? CS_SHIFT_RD : CS_DONE;
            end else begin
               state_in = CS_DONE;
            end
         end
         CS_INSERT: begin
            cmd.ins_wr = 1'b1;
            state_in   = CS_DONE;
         end
         CS_SHIFT_RD: begin
            if (sts.shift_end) begin
               state_in = CS_DEL_FILL;
            end else begin
               cmd.shift_rd = 1'b1;
               state_in     = CS_SHIFT_WR;
            end
         end
         CS_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = CS_SHIFT_RD;
         end
         CS_DEL_FILL: begin
            cmd.del_fill = 1'b1;
            state_in     = CS_DONE;
         end
         CS_DONE: begin
            // hold until the output register can take the result
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

`ifndef SYNTH
   a_load_starts_mod: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == CS_MOD))
      else $error("accepted request did not start the bucket reduction");
`endif

endmodule

// ===== rtl/core/cht_datapath.sv =====
`timescale 1ns / 1ps

module cht_datapath import cht_pkg::*; #(
   parameter int BUCKETS = BUCKETS_DEF,
   parameter int DEPTH   = DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  cht_cmd_type      cmd,
   output cht_sts_type      sts,
   input  logic [OP_W-1:0]  req_opcode,
   input  logic [KEY_W-1:0] req_key,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output logic             rsp_found,
   output logic [STS_W-1:0] rsp_status
);

   localparam int SLOTS = BUCKETS * DEPTH;
   localparam int BW    = $clog2(BUCKETS);
   localparam int RW    = BW + 1;
   localparam int FW    = $clog2(DEPTH + 1);
   localparam int AW    = $clog2(SLOTS);
   localparam int SH_W  = CHUNK_W * MOD_STEPS;

   logic [KEY_W-1:0] entry_mem [SLOTS];
   logic [FW-1:0]    fill_mem  [BUCKETS];
   logic [BUCKETS-1:0] fill_vld_ff, fill_vld_in;

   logic [OP_W-1:0]     op_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [SH_W-1:0]     sh_ff, sh_in;
   logic [RW-1:0]       rem_ff, rem_in;
   logic [MODCNT_W-1:0] modcnt_ff, modcnt_in;
   logic [AW-1:0]       base_ff;
   logic [FW-1:0]       fill_q_ff;
   logic                fill_vq_ff;
   logic [FW-1:0]       idx_ff, idx_in;
   logic                hit_ff, hit_in;
   logic [KEY_W-1:0]    rd_data_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff;
   logic [STS_W-1:0]    rsp_status_ff, rsp_status_in;

   logic [BW-1:0] bucket;
   logic [FW-1:0] n;
   logic [FW-1:0] idx_nx;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [KEY_W-1:0] wr_data;
   logic          mem_rd, mem_wr;
   logic          fill_wr;
   logic [FW-1:0] fill_wdata;
   logic          is_insert, is_delete, is_nop, full, match;

   assign bucket = rem_ff[BW-1:0];
   assign n      = fill_vq_ff ? fill_q_ff : '0;
   assign idx_nx = idx_ff + FW'(1);
   assign full   = (n >= FW'(DEPTH));
   assign match  = (rd_data_ff == key_ff);

   always_comb begin
      is_insert = 1'b0;
      is_delete = 1'b0;
      is_nop    = 1'b0;
      unique case (op_ff)
         OP_INSERT: is_insert = 1'b1;
         OP_SEARCH: ;
         OP_DELETE: is_delete = 1'b1;
         default:   is_nop = 1'b1;
      endcase
   end

   // reduce eight key bits per step, restoring one bit at a time
   always_comb begin
      logic [RW-1:0] r;
      r = rem_ff;
      for (int i = 0; i < CHUNK_W; i++) begin
         r = {r[RW-2:0], sh_ff[SH_W-1-i]};
         if (r >= RW'(BUCKETS)) begin
            r = r - RW'(BUCKETS);
         end
      end
      rem_in    = rem_ff;
      sh_in     = sh_ff;
      modcnt_in = modcnt_ff;
      if (cmd.load) begin
         rem_in    = '0;
         sh_in     = {1'b0, req_key};
         modcnt_in = '0;
      end else if (cmd.mod_step) begin
         rem_in    = r;
         sh_in     = {sh_ff[SH_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
         modcnt_in = modcnt_ff + MODCNT_W'(1);
      end
   end

   always_comb begin
      idx_in = idx_ff;
      hit_in = hit_ff;
      if (cmd.load) begin
         hit_in = 1'b0;
      end
      if (cmd.fill_rd) begin
         idx_in = '0;
      end
      if (cmd.scan_cmp) begin
         if (match) begin
            hit_in = 1'b1;
         end else begin
            idx_in = idx_nx;
         end
      end
      if (cmd.shift_wr) begin
         idx_in = idx_nx;
      end
   end

   // entry store port selection
   always_comb begin
      mem_rd  = cmd.scan_rd || cmd.shift_rd;
      rd_addr = cmd.shift_rd ? (base_ff + AW'(idx_nx)) : (base_ff + AW'(idx_ff));
      mem_wr  = cmd.ins_wr || cmd.shift_wr;
      wr_addr = cmd.ins_wr ? (base_ff + AW'(n)) : (base_ff + AW'(idx_ff));
      wr_data = cmd.ins_wr ? key_ff : rd_data_ff;
   end

   always_comb begin
      fill_wr     = cmd.ins_wr || cmd.del_fill;
      fill_wdata  = cmd.ins_wr ? (n + FW'(1)) : (n - FW'(1));
      fill_vld_in = fill_vld_ff;
      if (cmd.ins_wr) begin
         fill_vld_in[bucket] = 1'b1;
      end
   end

   always_comb begin
      priority if (is_insert && full) begin
         rsp_status_in = STS_FULL;
      end else if (is_delete && !hit_ff) begin
         rsp_status_in = STS_ABSENT;
      end else begin
         rsp_status_in = STS_OK;
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (mem_rd) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (fill_wr) begin
         fill_mem[bucket] <= fill_wdata;
      end
      if (cmd.fill_rd) begin
         fill_q_ff <= fill_mem[bucket];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_vld_ff  <= '0;
         modcnt_ff    <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_vld_ff  <= fill_vld_in;
         modcnt_ff    <= modcnt_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_opcode;
         key_ff <= req_key;
      end
      if (cmd.fill_rd) begin
         base_ff    <= AW'(32'(bucket) * DEPTH);
         fill_vq_ff <= fill_vld_ff[bucket];
      end
      if (cmd.rsp_load) begin
         rsp_found_ff  <= hit_ff;
         rsp_status_ff <= rsp_status_in;
      end
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
      idx_ff <= idx_in;
   end

   assign sts.mod_last  = (modcnt_ff == MODCNT_W'(MOD_STEPS - 1));
   assign sts.is_nop    = is_nop;
   assign sts.is_insert = is_insert;
   assign sts.is_delete = is_delete;
   assign sts.scan_end  = (idx_ff >= n);
   assign sts.match     = match;
   assign sts.hit       = hit_ff;
   assign sts.full      = full;
   assign sts.shift_end = (idx_nx >= n);
   assign sts.rsp_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_status = rsp_status_ff;

`ifndef SYNTH
   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_rd |-> (n <= FW'(DEPTH)))
      else $error("bucket fill count above depth");
   a_bucket_range: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_rd |-> (rem_ff < RW'(BUCKETS)))
      else $error("bucket index out of range");
   a_hit_from_scan: assert property (@(posedge clock) disable iff (reset)
      $rose(hit_ff) |-> $past(cmd.scan_cmp))
      else $error("hit set outside of a chain compare");
   a_shift_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.shift_wr |-> $past(cmd.shift_rd))
      else $error("entry moved without a prior read");
`endif

endmodule

// ===== rtl/core/chained_hash_table_core.sv =====
`timescale 1ns / 1ps
// Flow: the key is reduced to a bucket index, the bucket fill is read and the chain is
//   scanned to a hit or its end; insert then appends unless the bucket is full, delete
//   of a present key shifts the later entries down and lowers the fill, and an unused
//   opcode skips from the reduction to the response.
// Requests: one at a time; the next can be taken in the cycle the response goes valid.
// Reset: synchronous, active high; all bucket fills read as zero at once, no
//   clearing pass; entry memory is not cleared.
module chained_hash_table_core import cht_pkg::*; #(
   parameter int BUCKETS = BUCKETS_DEF,
   parameter int DEPTH   = DEPTH_DEF
) (
   input logic        clock,
   input logic        reset,
   cht_req_if.sink    req_chan,
   cht_rsp_if.source  rsp_chan
);

   cht_cmd_type cmd;
   cht_sts_type sts;

   cht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cht_datapath #(
      .BUCKETS (BUCKETS),
      .DEPTH   (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_opcode (req_chan.opcode),
      .req_key    (req_chan.key),
      .rsp_ready  (rsp_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .rsp_found  (rsp_chan.found),
      .rsp_status (rsp_chan.status)
   );

endmodule
